[rtl/core/mlk_pkg.sv]
// Shared types, constants and the Morse code table for the LED keyer.
// Used by every RTL file of the keyer except mlk_if.sv; depends on nothing else.

package mlk_pkg;

  // Message store geometry.
  localparam int MsgDepth = 64;
  localparam int PtrW     = (MsgDepth > 1) ? $clog2(MsgDepth) : 1;
  localparam int LenW     = $clog2(MsgDepth + 1);
  localparam int PosW     = 6;

  // Configuration port geometry.
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;
  localparam int TickW    = 16;

  // Reset values of the timing registers.
  localparam logic [TickW-1:0] DotReset       = 16'd2;
  localparam logic [TickW-1:0] DashReset      = 16'd6;
  localparam logic [TickW-1:0] PartGapReset   = 16'd2;
  localparam logic [TickW-1:0] LetterGapReset = 16'd6;
  localparam logic [TickW-1:0] WordGapReset   = 16'd14;

  // ASCII codes that the decoder looks at.
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrUpperZ = 8'h5A;
  localparam logic [7:0] ChrLowerA = 8'h61;
  localparam logic [7:0] ChrLowerZ = 8'h7A;
  localparam logic [5:0] DigitBase = 6'd26;

  typedef enum logic {
    OpWrite = 1'b0,
    OpTick  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    RegDot       = 3'd0,
    RegDash      = 3'd1,
    RegPartGap   = 3'd2,
    RegLetterGap = 3'd3,
    RegWordGap   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TickW-1:0] dot_ticks;
    logic [TickW-1:0] dash_ticks;
    logic [TickW-1:0] part_gap_ticks;
    logic [TickW-1:0] letter_gap_ticks;
    logic [TickW-1:0] word_gap_ticks;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       led;
    logic [PosW-1:0] position;
  } result_t;

  typedef struct packed {
    logic            en;
    logic [PtrW-1:0] addr;
    logic [7:0]      data;
  } mem_wr_t;

  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [4:0] bits;
  } code_info_t;

  // Element count and pattern (bit i is element i, 1 is a dash): A-Z, then 0-9.
  localparam logic [2:0] CodeLen [36] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };
  localparam logic [4:0] CodeBits [36] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
    5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  // Looks up a character; characters without a code come back with known low
  // and a length of zero.
  function automatic code_info_t char_info(input logic [7:0] c);
    code_info_t info;
    logic [5:0] k;
    info = '0;
    k    = '0;
    if (c >= ChrUpperA && c <= ChrUpperZ) begin
      k = 6'(c - ChrUpperA);
      info.known = 1'b1;
    end else if (c >= ChrLowerA && c <= ChrLowerZ) begin
      k = 6'(c - ChrLowerA);
      info.known = 1'b1;
    end else if (c >= ChrZero && c <= ChrNine) begin
      k = 6'(c - ChrZero) + DigitBase;
      info.known = 1'b1;
    end
    if (info.known) begin
      info.len  = CodeLen[k];
      info.bits = CodeBits[k];
    end
    return info;
  endfunction

endpackage

[rtl/core/mlk_if.sv]
// Valid/ready channel interfaces of the LED keyer: input items and results.
// Stand-alone; the payload widths match the fields of mlk_pkg.

interface mlk_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, op, char_code, last_char, input ready);
  modport sink   (input valid, op, char_code, last_char, output ready);
endinterface

interface mlk_out_if;
  logic       valid;
  logic       ready;
  logic       led;
  logic [5:0] position;

  modport source (output valid, led, position, input ready);
  modport sink   (input valid, led, position, output ready);
endinterface

[rtl/core/mlk_cfg_regs.sv]
// APB-style register file holding the five tick counts of the keyer.
// Depends on mlk_pkg for the register map and the cfg_t bundle.

module mlk_cfg_regs import mlk_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output cfg_t                cfg_o
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CfgAddrW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        RegDot:       cfg_nxt.dot_ticks        = pwdata[TickW-1:0];
        RegDash:      cfg_nxt.dash_ticks       = pwdata[TickW-1:0];
        RegPartGap:   cfg_nxt.part_gap_ticks   = pwdata[TickW-1:0];
        RegLetterGap: cfg_nxt.letter_gap_ticks = pwdata[TickW-1:0];
        RegWordGap:   cfg_nxt.word_gap_ticks   = pwdata[TickW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegDot:       prdata = CfgDataW'(cfg_r.dot_ticks);
      RegDash:      prdata = CfgDataW'(cfg_r.dash_ticks);
      RegPartGap:   prdata = CfgDataW'(cfg_r.part_gap_ticks);
      RegLetterGap: prdata = CfgDataW'(cfg_r.letter_gap_ticks);
      RegWordGap:   prdata = CfgDataW'(cfg_r.word_gap_ticks);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_ticks        <= DotReset;
      cfg_r.dash_ticks       <= DashReset;
      cfg_r.part_gap_ticks   <= PartGapReset;
      cfg_r.letter_gap_ticks <= LetterGapReset;
      cfg_r.word_gap_ticks   <= WordGapReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

[rtl/core/mlk_msg_store.sv]
// Message character memory: one write port, one registered read port.
// Depends on mlk_pkg for the depth and the write bundle.

module mlk_msg_store import mlk_pkg::*; (
  input  logic            clk,
  input  mem_wr_t         wr_i,
  input  logic [PtrW-1:0] rd_addr_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem [MsgDepth];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // A write to the address being read is forwarded into the read register as well.
  always_ff @(posedge clk) begin
    if (wr_i.en && wr_i.addr == rd_addr_i) begin
      rd_data_r <= wr_i.data;
    end else begin
      rd_data_r <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule

[rtl/core/mlk_seq.sv]
// Playback sequencer: write pointer, play position and element timing.
// Depends on mlk_pkg for the code table and the bundles it exchanges.

module mlk_seq import mlk_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc_i,
  input  in_item_t        item_i,
  input  cfg_t            cfg_i,
  input  logic [7:0]      cur_char_i,
  output mem_wr_t         wr_o,
  output logic [PtrW-1:0] rd_addr_o,
  output result_t         res_o
);

  logic [LenW-1:0]  len_r, len_nxt;
  logic [PtrW-1:0]  wp_r, wp_nxt;
  logic [PtrW-1:0]  pp_r, pp_nxt;
  logic [2:0]       ei_r, ei_nxt;
  logic [TickW-1:0] tc_r, tc_nxt;
  logic [TickW-1:0] pl_r, pl_nxt;
  logic             led_r, led_nxt;
  logic             inl_r, inl_nxt;

  code_info_t       info;
  logic [LenW-1:0]  wp_inc;
  logic [LenW-1:0]  pp_inc;
  logic [PtrW-1:0]  wp_wrap;
  logic [PtrW-1:0]  pp_adv;
  logic [2:0]       ei_inc;
  logic [4:0]       bits_sh;
  logic             end_letter;
  logic [PtrW+PosW-1:0] pos_ext;

  assign info    = char_info(cur_char_i);
  assign wp_inc  = LenW'(wp_r) + LenW'(1);
  assign pp_inc  = LenW'(pp_r) + LenW'(1);
  assign wp_wrap = (wp_inc == LenW'(MsgDepth)) ? '0 : wp_inc[PtrW-1:0];
  assign pp_adv  = (pp_inc >= len_r) ? '0 : pp_inc[PtrW-1:0];
  assign ei_inc  = ei_r + 3'd1;
  assign bits_sh = info.bits >> ei_r;

  always_comb begin
    len_nxt    = len_r;
    wp_nxt     = wp_r;
    pp_nxt     = pp_r;
    ei_nxt     = ei_r;
    tc_nxt     = tc_r;
    pl_nxt     = pl_r;
    led_nxt    = led_r;
    inl_nxt    = inl_r;
    wr_o       = '0;
    end_letter = 1'b0;

    if (acc_i) begin
      if (item_i.op == OpWrite) begin
        wr_o.en   = 1'b1;
        wr_o.addr = wp_r;
        wr_o.data = item_i.char_code;
        if (item_i.last_char) begin
          len_nxt = wp_inc;
          wp_nxt  = '0;
          pp_nxt  = '0;
          ei_nxt  = '0;
          tc_nxt  = '0;
          pl_nxt  = '0;
          led_nxt = 1'b0;
          inl_nxt = 1'b0;
        end else begin
          wp_nxt = wp_wrap;
        end
      end else if (len_r == '0) begin
        led_nxt = 1'b0;
      end else if (tc_r >= pl_r) begin
        tc_nxt = TickW'(1);
        if (!inl_r) begin
          ei_nxt = '0;
          if (cur_char_i == ChrSpace) begin
            pp_nxt  = pp_adv;
            led_nxt = 1'b0;
            pl_nxt  = cfg_i.word_gap_ticks;
          end else if (!info.known) begin
            pp_nxt  = pp_adv;
            led_nxt = 1'b0;
            pl_nxt  = cfg_i.letter_gap_ticks;
          end else begin
            inl_nxt = 1'b1;
            led_nxt = 1'b1;
            pl_nxt  = info.bits[0] ? cfg_i.dash_ticks : cfg_i.dot_ticks;
          end
        end else if (led_r) begin
          if (ei_inc >= info.len) begin
            end_letter = 1'b1;
          end else begin
            ei_nxt  = ei_inc;
            led_nxt = 1'b0;
            pl_nxt  = cfg_i.part_gap_ticks;
          end
        end else begin
          if (ei_r >= info.len) begin
            end_letter = 1'b1;
          end else begin
            led_nxt = 1'b1;
            pl_nxt  = bits_sh[0] ? cfg_i.dash_ticks : cfg_i.dot_ticks;
          end
        end
        if (end_letter) begin
          inl_nxt = 1'b0;
          ei_nxt  = '0;
          pp_nxt  = pp_adv;
          led_nxt = 1'b0;
          pl_nxt  = cfg_i.letter_gap_ticks;
        end
      end else begin
        tc_nxt = tc_r + TickW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      wp_r  <= '0;
      pp_r  <= '0;
      ei_r  <= '0;
      tc_r  <= '0;
      pl_r  <= '0;
      led_r <= 1'b0;
      inl_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      wp_r  <= wp_nxt;
      pp_r  <= pp_nxt;
      ei_r  <= ei_nxt;
      tc_r  <= tc_nxt;
      pl_r  <= pl_nxt;
      led_r <= led_nxt;
      inl_r <= inl_nxt;
    end
  end

  // The store is read at the position that is current in the next cycle.
  assign rd_addr_o = pp_nxt;

  assign pos_ext        = (PtrW+PosW)'(pp_nxt);
  assign res_o.led      = led_nxt;
  assign res_o.position = pos_ext[PosW-1:0];

endmodule

[rtl/core/morse_led_keyer.sv]
// Top level of the Morse LED keyer: channels, register port and result register.
// Depends on mlk_pkg, the channel interfaces, mlk_cfg_regs, mlk_msg_store, mlk_seq.
//
//   Channel   Direction  Handshake            Payload
//   in_ch     sink       valid/ready          op, char_code, last_char
//   out_ch    source     valid/ready          led, position
//   APB       slave      psel/penable, pready paddr, pwdata, prdata
//
// Every transaction on in_ch is handled in the cycle it is accepted; its one result
// is registered and shown on out_ch from the next cycle on, and one transaction per
// clock is sustained while out_ch is ready: the result register refills as it drains.
// rst_n (synchronous, active low) restores the default tick counts, an empty
// message and an empty result register; the message memory is not cleared.
// A stalled result holds its value and blocks further input until it is taken.

module morse_led_keyer import mlk_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  mlk_in_if.sink              in_ch,
  mlk_out_if.source           out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t            cfg;
  in_item_t        item;
  mem_wr_t         wr;
  logic [PtrW-1:0] rd_addr;
  logic [7:0]      cur_char;
  result_t         res;
  logic            in_acc;

  logic            out_valid_r, out_valid_nxt;
  result_t         out_res_r;

  // Registers accept every access in a single access phase.
  assign pready = 1'b1;

  mlk_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // A new item may enter whenever the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign item.op        = op_t'(in_ch.op);
  assign item.char_code = in_ch.char_code;
  assign item.last_char = in_ch.last_char;

  // The memory always holds the character at the current play position on its
  // read output, including a character written in the previous cycle.
  mlk_msg_store u_store (
    .clk       (clk),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (cur_char)
  );

  mlk_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_i      (in_acc),
    .item_i     (item),
    .cfg_i      (cfg),
    .cur_char_i (cur_char),
    .wr_o       (wr),
    .rd_addr_o  (rd_addr),
    .res_o      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: loaded with every accepted item, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.led      = out_res_r.led;
  assign out_ch.position = out_res_r.position;

endmodule

[rtl/core/mlk_checker.sv]
// Port-level checks on the keyer's channels, bound to the top level.
// Depends on morse_led_keyer and mlk_pkg for the operation codes.

module mlk_checker import mlk_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_op,
  input logic       in_last_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_led,
  input logic [5:0] out_position
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With no result pending the block must take input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Closing a message restarts playback: LED off at the first character.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OpWrite && in_last_char) |=>
      (out_valid && !out_led && out_position == 6'd0))
    else $error("message load did not restart playback");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_led) && $stable(out_position)))
    else $error("stalled result changed");

endmodule

bind morse_led_keyer mlk_checker u_mlk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_op        (in_ch.op),
  .in_last_char (in_ch.last_char),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_led      (out_ch.led),
  .out_position (out_ch.position)
);

[bench/testbench.sv]
// Self-checking bench for the Morse LED keyer: message writes, ticks and timing registers.
// Depends on mlk_pkg, the channel interfaces in mlk_if.sv and the morse_led_keyer RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mlk_pkg::*;

  // Register indexes past the end of the timing block. Writes there must be ignored.
  localparam int UnusedReg = RegWordGap + 1;

  // Morse element counts and patterns, letters A-Z then digits 0-9.
  // Bit i of a pattern is element i of the character, and a set bit is a dash.
  localparam int MorseLen [36] = '{
    2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4,
    5, 5, 5, 5, 5, 5, 5, 5, 5, 5
  };
  localparam logic [4:0] MorsePattern [36] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
    5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  // One set of the five timing registers.
  typedef struct {
    int dot;
    int dash;
    int part_gap;
    int letter_gap;
    int word_gap;
  } timing_t;

  // One row of the opening directed sequence. When pinned is set, the expected
  // LED level and position are given in the row instead of being predicted.
  typedef struct {
    op_t        op;
    logic [7:0] ch;
    logic       last;
    bit         pinned;
    logic       led;
    logic [5:0] pos;
  } step_row_t;

  logic clk;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  mlk_in_if  in_ch ();
  mlk_out_if out_ch ();

  morse_led_keyer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the timing registers, starting at their reset values.
  int t_dot    = 2;
  int t_dash   = 6;
  int t_part   = 2;
  int t_letter = 6;
  int t_word   = 14;

  // Predicted keyer state. The message store is only ever read at entries that
  // the stimulus has written, so it needs no reset value here.
  logic [7:0] ks_store [MsgDepth];
  int ks_len       = 0;
  int ks_wp        = 0;
  int ks_pos       = 0;
  int ks_elem      = 0;
  int ks_tick      = 0;
  int ks_phase     = 0;
  bit ks_led       = 1'b0;
  bit ks_in_letter = 1'b0;

  // LED levels and positions still owed by the block, oldest first.
  result_t pending_keying [$];

  // Pinned expectation that travels with the transaction currently offered.
  logic    item_pinned;
  result_t item_pin;

  // Idling controls: send_idle_pct for the sender, recv_idle_pct and recv_hold for the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold     = 0;

  int items_sent    = 0;
  int n_writes      = 0;
  int n_ticks       = 0;
  int n_checked     = 0;
  int n_settings    = 0;
  int failures      = 0;

  // The opening sequence. It starts on an empty message, keys a one-character
  // message with no Morse code, rewrites the store underneath that playback with
  // the letter and digit extremes, a space and a codeless byte, then restarts
  // and keys the first letter through its dot, its part gap and its dash.
  step_row_t opening_rows [25] = '{
    '{OpTick,  8'hFF,     1'b1, 1'b1, 1'b0, 6'd0},
    '{OpTick,  8'h00,     1'b0, 1'b1, 1'b0, 6'd0},
    '{OpWrite, 8'h00,     1'b1, 1'b1, 1'b0, 6'd0},
    '{OpTick,  8'h55,     1'b0, 1'b1, 1'b0, 6'd0},
    '{OpWrite, ChrUpperA, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, ChrUpperZ, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, ChrSpace,  1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, ChrLowerA, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, ChrLowerZ, 1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, ChrZero,   1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, ChrNine,   1'b0, 1'b0, 1'b0, 6'd0},
    '{OpWrite, 8'hFF,     1'b1, 1'b1, 1'b0, 6'd0},
    '{OpTick,  8'hAA,     1'b1, 1'b1, 1'b1, 6'd0},
    '{OpTick,  8'h01,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h80,     1'b1, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h00,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h7F,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h20,     1'b1, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h00,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h41,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h00,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'hC3,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h00,     1'b0, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h3C,     1'b1, 1'b0, 1'b0, 6'd0},
    '{OpTick,  8'h00,     1'b0, 1'b0, 1'b0, 6'd0}
  };

  // ---------------------------------------------------------------------------
  // Keying predictor
  // ---------------------------------------------------------------------------

  // Table slot of a character, or -1 when the character has no Morse code.
  function automatic int code_slot(logic [7:0] c);
    if (c >= ChrUpperA && c <= ChrUpperZ) return int'(c - ChrUpperA);
    if (c >= ChrLowerA && c <= ChrLowerZ) return int'(c - ChrLowerA);
    if (c >= ChrZero && c <= ChrNine) return int'(c - ChrZero) + 26;
    return -1;
  endfunction

  // Every phase counts its first tick as soon as it opens.
  function automatic void open_phase(bit on, int len);
    ks_led   = on;
    ks_phase = len;
    ks_tick  = 1;
  endfunction

  // Playback wraps back to the first character at the end of the message.
  function automatic void next_char_pos();
    ks_pos = (ks_pos + 1 >= ks_len) ? 0 : ks_pos + 1;
  endfunction

  function automatic void finish_letter();
    ks_in_letter = 1'b0;
    ks_elem      = 0;
    next_char_pos();
    open_phase(1'b0, t_letter);
  endfunction

  function automatic void key_element(int slot);
    open_phase(1'b1, MorsePattern[slot][ks_elem] ? t_dash : t_dot);
  endfunction

  // Applies one transaction to the predicted state and returns the LED level
  // and the position that the block must show for it.
  function automatic result_t key_item(op_t op, logic [7:0] ch, logic last);
    result_t    res;
    logic [7:0] c;
    int         slot;
    int         n;
    int         wp;
    if (op == OpWrite) begin
      wp = ks_wp % MsgDepth;
      ks_store[wp] = ch;
      if (last) begin
        // The final character fixes the length and restarts playback dark.
        ks_len       = wp + 1;
        ks_wp        = 0;
        ks_pos       = 0;
        ks_elem      = 0;
        ks_tick      = 0;
        ks_phase     = 0;
        ks_led       = 1'b0;
        ks_in_letter = 1'b0;
      end else begin
        ks_wp = (wp + 1) % MsgDepth;
      end
    end else if (ks_len == 0) begin
      ks_led = 1'b0;
    end else if (ks_tick >= ks_phase) begin
      // The current phase has run its course, so decide what comes next from
      // the character under the play position as it reads right now.
      c    = ks_store[ks_pos % MsgDepth];
      slot = code_slot(c);
      n    = (slot < 0) ? 0 : MorseLen[slot];
      if (!ks_in_letter) begin
        ks_elem = 0;
        if (c == ChrSpace) begin
          next_char_pos();
          open_phase(1'b0, t_word);
        end else if (slot < 0) begin
          next_char_pos();
          open_phase(1'b0, t_letter);
        end else begin
          ks_in_letter = 1'b1;
          key_element(slot);
        end
      end else if (ks_led) begin
        ks_elem++;
        if (ks_elem >= n) finish_letter();
        else open_phase(1'b0, t_part);
      end else begin
        if (ks_elem >= n) finish_letter();
        else key_element(slot);
      end
    end else begin
      ks_tick++;
    end
    res.led      = ks_led;
    res.position = ks_pos[PosW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit and failure reporting
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A correct run ends long before this limit, even with the heavy receiver stalls.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_failure(string msg);
    if (failures < 100) $display("ERROR at %0t ns: %s", $time, msg);
    failures++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predicts at each accepted input transaction and checks each
  // accepted result against the oldest expectation. Signals are read at the
  // clock edge, before any of this edge's nonblocking updates land.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = key_item(op_t'(in_ch.op), in_ch.char_code, in_ch.last_char);
        if (item_pinned) want = item_pin;
        pending_keying.push_back(want);
        if (in_ch.op == OpTick) n_ticks++;
        else n_writes++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.led      = out_ch.led;
        got.position = out_ch.position;
        if (pending_keying.size() == 0) begin
          report_failure($sformatf("result led=%b position=%0d with nothing expected",
                                   got.led, got.position));
        end else begin
          want = pending_keying.pop_front();
          n_checked++;
          if (got.led !== want.led)
            report_failure($sformatf("result %0d: led %b, expected %b",
                                     n_checked, got.led, want.led));
          if (got.position !== want.position)
            report_failure($sformatf("result %0d: position %0d, expected %0d",
                                     n_checked, got.position, want.position));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request. The
  // hold-off is counted down here so that the sender keeps offering meanwhile.
  // ---------------------------------------------------------------------------

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        out_ch.ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Each transfer starts with its setup cycle right after the previous access
  // cycle, so the select lines are only dropped once at the end of a burst.
  task automatic cfg_write(int idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegDot:       t_dot    = int'(val[TickW-1:0]);
      RegDash:      t_dash   = int'(val[TickW-1:0]);
      RegPartGap:   t_part   = int'(val[TickW-1:0]);
      RegLetterGap: t_letter = int'(val[TickW-1:0]);
      RegWordGap:   t_word   = int'(val[TickW-1:0]);
      default: ;
    endcase
  endtask

  task automatic cfg_read(int idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CfgAddrW'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
  endtask

  // Reads every timing register back, compares it with the mirror and ends
  // the burst on the register port.
  task automatic check_timing();
    logic [31:0] got;
    int          want [5];
    want[RegDot]       = t_dot;
    want[RegDash]      = t_dash;
    want[RegPartGap]   = t_part;
    want[RegLetterGap] = t_letter;
    want[RegWordGap]   = t_word;
    for (int i = RegDot; i <= RegWordGap; i++) begin
      cfg_read(i, got);
      if (got[TickW-1:0] !== TickW'(want[i]))
        report_failure($sformatf("register %0d reads %0d, expected %0d",
                                 i, got[TickW-1:0], want[i]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Writes a full timing set plus one write past the register list, which the
  // block must ignore, then reads everything back.
  task automatic apply_timing(timing_t t);
    cfg_write(RegDot, t.dot);
    cfg_write(RegDash, t.dash);
    cfg_write(RegPartGap, t.part_gap);
    cfg_write(RegLetterGap, t.letter_gap);
    cfg_write(RegWordGap, t.word_gap);
    cfg_write(UnusedReg + $urandom_range(0, 2), $urandom());
    check_timing();
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one transaction and returns at the edge that accepts it. Valid is
  // left high so that a following transaction can go out without a gap.
  task automatic put_item(op_t op, logic [7:0] ch, logic last,
                          bit pinned = 1'b0, result_t pin = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.char_code <= ch;
    in_ch.last_char <= last;
    item_pinned     <= pinned;
    item_pin        <= pin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_keying.size() != 0) @(posedge clk);
  endtask

  // Mostly keyable characters, with spaces and arbitrary bytes mixed in.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return ChrUpperA + 8'($urandom_range(0, 25));
    if (r < 50) return ChrLowerA + 8'($urandom_range(0, 25));
    if (r < 65) return ChrZero + 8'($urandom_range(0, 9));
    if (r < 80) return ChrSpace;
    return 8'($urandom_range(0, 255));
  endfunction

  // One stretch of traffic: usually a complete message followed by a run of
  // ticks to key it, now and then an unfinished message instead. Ticks carry
  // random filler in their unused fields, and a few stray writes land during
  // playback so that the character being keyed can change under the block.
  task automatic keying_session();
    int r;
    int n;
    int ticks;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 3);
      repeat (n) put_item(OpWrite, 8'($urandom_range(0, 255)), 1'b0);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 6);
      else if (r < 88) n = $urandom_range(7, 20);
      else if (r < 95) n = $urandom_range(21, MsgDepth - 1);
      else if (r < 97) n = MsgDepth;
      else n = $urandom_range(MsgDepth + 1, MsgDepth + 16);
      for (int i = 0; i < n; i++) put_item(OpWrite, pick_char(), i == n - 1);
    end
    ticks = $urandom_range(8, 90);
    repeat (ticks) begin
      if ($urandom_range(0, 99) < 4) put_item(OpWrite, pick_char(), 1'b0);
      else put_item(OpTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Runs sessions until about the given number of transactions went out. At
  // session hold_at the receiver holds off for a long stretch while the sender
  // keeps offering; at session pause_at the sender waits for all results first.
  task automatic run_phase(int items, int hold_at, int pause_at);
    int stop_at;
    int session;
    stop_at = items_sent + items;
    session = 0;
    while (items_sent < stop_at) begin
      if (session == hold_at) recv_hold = 60;
      if (session == pause_at) drain_results();
      keying_session();
      session++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    timing_t classic;
    timing_t zeroed;
    timing_t widest;
    timing_t mixed;
    result_t pin;

    // The classic 1:3:7 ratios at the shortest dot; a set with zero times,
    // which behave like one tick; every register at its maximum; and a random
    // short set for the final stretch.
    classic = '{1, 3, 1, 3, 7};
    zeroed  = '{0, 2, 0, 1, 0};
    widest  = '{65535, 65535, 65535, 65535, 65535};
    mixed.dot        = $urandom_range(1, 5);
    mixed.dash       = $urandom_range(1, 5);
    mixed.part_gap   = $urandom_range(1, 5);
    mixed.letter_gap = $urandom_range(1, 5);
    mixed.word_gap   = $urandom_range(1, 5);

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OpWrite;
    in_ch.char_code <= 8'h00;
    in_ch.last_char <= 1'b0;
    item_pinned     <= 1'b0;
    item_pin        <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The registers must come out of reset at their default tick counts.
    check_timing();

    // Directed opening under the default timing, with the first idling mix.
    send_idle_pct = 9;
    recv_idle_pct = 66;
    foreach (opening_rows[i]) begin
      pin.led      = opening_rows[i].led;
      pin.position = opening_rows[i].pos;
      put_item(opening_rows[i].op, opening_rows[i].ch, opening_rows[i].last,
               opening_rows[i].pinned, pin);
    end

    // Random traffic with a busy sender and a reluctant receiver. One long
    // receiver hold-off fills the result register and stalls the input.
    drain_results();
    apply_timing(classic);
    run_phase(360, 3, -1);

    // The other way round: a bursty sender against an eager receiver. Here the
    // sender once stops and waits until every result has come back.
    drain_results();
    send_idle_pct = 66;
    recv_idle_pct = 9;
    apply_timing(zeroed);
    run_phase(360, -1, 4);

    // Maximum tick counts: a message of one digit whose first dash keeps the
    // LED on for far longer than the ticks that follow.
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_timing(widest);
    put_item(OpWrite, ChrZero, 1'b1);
    repeat (39) put_item(OpTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // Neither side idles for the last stretch.
    drain_results();
    apply_timing(mixed);
    run_phase(360, -1, -1);

    // Let the block settle, then catch stray or missing results.
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_keying.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_keying.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_keying.size()));

    $display("Sent %0d transactions: %0d character writes and %0d ticks, over %0d timing sets.",
             items_sent, n_writes, n_ticks, n_settings);
    $display("Compared %0d results, %0d failures.", n_checked, failures);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
